/* hdl/canf_pkg.sv */
`timescale 1ns / 1ps
// Shared widths, register indexes, reset values and types for the cascaded notch filter.
// No dependencies; every other file imports it.
package canf_pkg;

  localparam int SAMPLE_W = 16;
  localparam int OUT_W    = 21;
  localparam int REG_W    = 15;
  localparam int IDX_W    = 3;
  localparam int RAD_W    = 16;
  localparam int COEF_W   = 16;
  localparam int RND_W    = 14;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_FORGET = 3'd0;
  localparam logic [IDX_W-1:0] REG_TARGET = 3'd1;
  localparam logic [IDX_W-1:0] REG_FINAL  = 3'd2;
  localparam logic [IDX_W-1:0] REG_START  = 3'd3;
  localparam logic [IDX_W-1:0] REG_STEP   = 3'd4;

  localparam logic [REG_W-1:0] FORGET_RST = 15'd29491;
  localparam logic [REG_W-1:0] TARGET_RST = 15'd3276;
  localparam logic [REG_W-1:0] FINAL_RST  = 15'd31130;
  localparam logic [REG_W-1:0] START_RST  = 15'd16384;
  localparam logic [REG_W-1:0] STEP_RST   = 15'd200;

  localparam logic signed [COEF_W-1:0] COEF_MAX = 16'sh4000;
  localparam logic signed [COEF_W-1:0] COEF_MIN = 16'shC000;  // -0x4000

  // feedback rounding constant, differs per stage
  localparam logic [RND_W-1:0] FB_RND_ST1 = 14'h2000;
  localparam logic [RND_W-1:0] FB_RND_ST2 = 14'h0400;

  typedef struct packed {
    logic e_vld;  // stage output register just loaded
    logic done;   // last step of the stage update
  } cell_stat_t;

endpackage

/* hdl/canf_in_if.sv */
`timescale 1ns / 1ps
// Input sample channel: valid/ready handshake carrying one signed sample per item.
// Depends on canf_pkg.
interface canf_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [canf_pkg::SAMPLE_W-1:0]   sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

/* hdl/canf_out_if.sv */
`timescale 1ns / 1ps
// Result channel: valid/ready handshake carrying both stage outputs per item.
// Depends on canf_pkg.
interface canf_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [canf_pkg::OUT_W-1:0]    stage_one_out;
  logic signed [canf_pkg::OUT_W-1:0]    stage_two_out;

  modport source (output valid, output stage_one_out, output stage_two_out, input ready);
  modport sink   (input valid, input stage_one_out, input stage_two_out, output ready);
endinterface

/* hdl/canf_cfg_if.sv */
`timescale 1ns / 1ps
// Configuration write channel: valid/ready handshake with register index and data.
// Depends on canf_pkg.
interface canf_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [canf_pkg::IDX_W-1:0]     index;
  logic [canf_pkg::REG_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* hdl/cascaded_adaptive_notch_filter.sv */
`timescale 1ns / 1ps
// Top level of the two-stage adaptive notch filter: config registers, item control, output register.
// Depends on canf_pkg, the canf_*_if interfaces, canf_radius and canf_cell.
//
// Each accepted sample item yields one result item carrying both saturated stage outputs.
// An item runs from acceptance until the next sample can be taken: the radius update on the
// radius unit's shared multiplier, then eight steps (six products on one shared multiplier)
// in each notch cell, with stage two starting as soon as stage one's output register is
// loaded, then the move of the result into the output register and the idle state in which
// the next item is taken. The result waits there for the consumer; the block returns to idle
// as soon as it is loaded. Configuration writes are taken at any time (cfg_ch.ready is always
// high) but should be issued only while no item is in flight; writing start_radius also
// reloads the pole radius.
module cascaded_adaptive_notch_filter (
  input  logic        clk,
  input  logic        rst_n,
  canf_in_if.sink     in_ch,
  canf_out_if.source  out_ch,
  canf_cfg_if.sink    cfg_ch
);
  import canf_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_BUSY = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  logic [1:0]                 state_r, state_nxt;
  logic [REG_W-1:0]           forget_r, target_r, final_r, step_r;
  logic signed [SAMPLE_W-1:0] x_r;
  logic signed [OUT_W-1:0]    x1, e1, e2;
  logic signed [OUT_W-1:0]    out1_r, out2_r;
  logic                       out_valid_r;
  logic                       in_acc, cfg_wr, out_ld, ld_start;
  logic                       rad_done;
  logic [RAD_W-1:0]           radius;
  logic signed [RAD_W-1:0]    rsq;
  cell_stat_t                 st1, st2;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_wr       = cfg_ch.valid && cfg_ch.ready;
  assign ld_start     = cfg_wr && cfg_ch.index == REG_START;
  assign out_ld       = (state_r == ST_OUT) && (!out_valid_r || out_ch.ready);
  assign x1           = OUT_W'(x_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      forget_r <= FORGET_RST;
      target_r <= TARGET_RST;
      final_r  <= FINAL_RST;
      step_r   <= STEP_RST;
    end else if (cfg_wr) begin
      unique case (cfg_ch.index)
        REG_FORGET: forget_r <= cfg_ch.data;
        REG_TARGET: target_r <= cfg_ch.data;
        REG_FINAL:  final_r  <= cfg_ch.data;
        REG_STEP:   step_r   <= cfg_ch.data;
        default: ;  // start radius lives in the radius unit; other indexes ignored
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_BUSY;
      ST_BUSY: if (st2.done) state_nxt = ST_OUT;
      ST_OUT:  if (out_ld) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_ld) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      x_r <= in_ch.sample;
    end
    if (out_ld) begin
      out1_r <= e1;
      out2_r <= e2;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.stage_one_out = out1_r;
  assign out_ch.stage_two_out = out2_r;

  canf_radius u_radius (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_acc),
    .ld       (ld_start),
    .ld_val   (cfg_ch.data),
    .forget_w (forget_r),
    .target_w (target_r),
    .final_r  (final_r),
    .radius   (radius),
    .rsq      (rsq),
    .done     (rad_done)
  );

  canf_cell u_cell1 (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (rad_done),
    .x      (x1),
    .radius (radius),
    .rsq    (rsq),
    .step   (step_r),
    .fb_rnd (FB_RND_ST1),
    .stat   (st1),
    .e      (e1)
  );

  // stage two starts on stage one's output
  canf_cell u_cell2 (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (st1.e_vld),
    .x      (e1),
    .radius (radius),
    .rsq    (rsq),
    .step   (step_r),
    .fb_rnd (FB_RND_ST2),
    .stat   (st2),
    .e      (e2)
  );

  a_acc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == ST_BUSY)
    else $error("accepted item did not start processing");

  a_cells_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st1.done || st2.done || rad_done) |-> state_r == ST_BUSY)
    else $error("datapath finished outside of busy state");

  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_OUT))
    else $error("result raised without a finished item");

endmodule

/* hdl/canf_radius.sv */
`timescale 1ns / 1ps
// Pole radius update: r' = rnd15(fw*r) + rnd15(tw*fr), saturated, then rnd15(r'^2).
// Uses one shared 16x16 unsigned multiplier over the FW, TW, SUM, SQ and RSQ phases. Depends on canf_pkg.
module canf_radius (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic                                ld,
  input  logic [canf_pkg::REG_W-1:0]          ld_val,
  input  logic [canf_pkg::REG_W-1:0]          forget_w,
  input  logic [canf_pkg::REG_W-1:0]          target_w,
  input  logic [canf_pkg::REG_W-1:0]          final_r,
  output logic [canf_pkg::RAD_W-1:0]          radius,
  output logic signed [canf_pkg::RAD_W-1:0]   rsq,
  output logic                                done
);
  import canf_pkg::*;

  localparam int PW = 2 * RAD_W;
  localparam logic [2:0] PH_FW  = 3'd0;
  localparam logic [2:0] PH_TW  = 3'd1;
  localparam logic [2:0] PH_SUM = 3'd2;
  localparam logic [2:0] PH_SQ  = 3'd3;
  localparam logic [2:0] PH_RSQ = 3'd4;

  logic                     busy_r;
  logic [2:0]               ph_r;
  logic [RAD_W-1:0]         radius_r;
  logic signed [RAD_W-1:0]  rsq_r;
  logic [RAD_W:0]           t1_r;
  logic [RAD_W-1:0]         ma, mb;
  logic [PW-1:0]            prod_r;
  logic [PW:0]              rsum;
  logic [RAD_W+1:0]         rnd15, sum;
  logic [RAD_W-1:0]         radius_nxt;

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (ph_r)
      PH_FW: begin
        ma = {1'b0, forget_w};
        mb = radius_r;
      end
      PH_TW: begin
        ma = {1'b0, target_w};
        mb = {1'b0, final_r};
      end
      PH_SQ: begin
        ma = radius_r;
        mb = radius_r;
      end
      default: ;
    endcase
  end

  always_comb begin
    rsum       = {1'b0, prod_r} + 33'd16384;
    rnd15      = rsum[PW:15];
    sum        = {1'b0, t1_r} + rnd15;
    radius_nxt = (sum > 18'h0FFFF) ? '1 : sum[RAD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      ph_r     <= PH_FW;
      radius_r <= {1'b0, START_RST};
    end else begin
      if (start) begin
        busy_r <= 1'b1;
        ph_r   <= PH_FW;
      end else if (busy_r) begin
        ph_r <= ph_r + 3'd1;
        if (ph_r == PH_RSQ) begin
          busy_r <= 1'b0;
        end
      end
      if (ld) begin
        radius_r <= {1'b0, ld_val};
      end else if (busy_r && ph_r == PH_SUM) begin
        radius_r <= radius_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= ma * mb;
    if (busy_r && ph_r == PH_TW) begin
      t1_r <= rnd15[RAD_W:0];
    end
    if (busy_r && ph_r == PH_RSQ) begin
      rsq_r <= rnd15[RAD_W-1:0];
    end
  end

  assign radius = radius_r;
  assign rsq    = rsq_r;
  assign done   = busy_r && ph_r == PH_RSQ;

endmodule

/* hdl/canf_cell.sv */
`timescale 1ns / 1ps
// One adaptive notch section: holds its coefficient and two past internal values,
// computes six products over eight steps on a shared 21x16 multiplier. Depends on canf_pkg.
module canf_cell (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [canf_pkg::OUT_W-1:0]   x,
  input  logic [canf_pkg::RAD_W-1:0]          radius,
  input  logic signed [canf_pkg::RAD_W-1:0]   rsq,
  input  logic [canf_pkg::REG_W-1:0]          step,
  input  logic [canf_pkg::RND_W-1:0]          fb_rnd,
  output canf_pkg::cell_stat_t                stat,
  output logic signed [canf_pkg::OUT_W-1:0]   e
);
  import canf_pkg::*;

  localparam int MA_W   = OUT_W;
  localparam int MB_W   = COEF_W;
  localparam int P_W    = MA_W + MB_W;
  localparam int FF_W   = 24;
  localparam int FBQ_W  = 19;
  localparam int FB2_W  = 21;
  localparam int ACC_W  = 26;
  localparam int ES_W   = 25;
  localparam int GU_W   = 23;
  localparam int CN_W   = COEF_W + 1;

  // phase names tell what the multiplier is fed; its product is used one phase later
  localparam logic [2:0] PH_CW   = 3'd0;  // c*w1
  localparam logic [2:0] PH_RW   = 3'd1;  // r*w1
  localparam logic [2:0] PH_RSQ  = 3'd2;  // w2*r^2
  localparam logic [2:0] PH_FB   = 3'd3;  // c*fbq
  localparam logic [2:0] PH_STEP = 3'd4;  // step*w1
  localparam logic [2:0] PH_ERR  = 3'd5;  // idle, output formed
  localparam logic [2:0] PH_GRAD = 3'd6;  // e*g
  localparam logic [2:0] PH_UPD  = 3'd7;  // coefficient and delay update

  logic                       busy_r;
  logic [2:0]                 ph_r;
  logic signed [COEF_W-1:0]   coef_r, w1_r, w2_r;
  logic signed [MA_W-1:0]     ma;
  logic signed [MB_W-1:0]     mb;
  logic signed [P_W-1:0]      prod_r, prod_nxt;
  logic signed [FF_W-1:0]     ff_r, ff_nxt;
  logic signed [FBQ_W-1:0]    fbq_r;
  logic signed [FB2_W-1:0]    fb2_r;
  logic signed [COEF_W-1:0]   sn_r, g_r;
  logic signed [OUT_W-1:0]    e_r, e_nxt;
  logic signed [P_W-1:0]      ff_full, rnd10, fbq_full, fb2_full, fb1_full, g2_full;
  logic signed [ACC_W-1:0]    acc;
  logic signed [ES_W-1:0]     esum;
  logic signed [GU_W-1:0]     gu;
  logic signed [COEF_W-1:0]   dstep;
  logic signed [CN_W-1:0]     cnew;
  logic signed [COEF_W-1:0]   coef_nxt;

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (ph_r)
      PH_CW: begin
        ma = MA_W'(coef_r);
        mb = w1_r;
      end
      PH_RW: begin
        ma = MA_W'(signed'({1'b0, radius}));
        mb = w1_r;
      end
      PH_RSQ: begin
        ma = MA_W'(rsq);
        mb = w2_r;
      end
      PH_FB: begin
        ma = MA_W'(fbq_r);
        mb = coef_r;
      end
      PH_STEP: begin
        ma = MA_W'(signed'({1'b0, step}));
        mb = w1_r;
      end
      PH_GRAD: begin
        ma = e_r;
        mb = g_r;
      end
      default: ;
    endcase
    prod_nxt = ma * mb;
  end

  always_comb begin
    // feed-forward term from -c*w1
    ff_full  = (-prod_r + 37'sd256) >>> 9;
    ff_nxt   = FF_W'(ff_full) + (FF_W'(w2_r) <<< 4);
    // two rounding shifts of r*w1 fold into one
    rnd10    = prod_r + 37'sd1024;
    fbq_full = rnd10 >>> 13;
    fb2_full = rnd10 >>> 11;
    fb1_full = (prod_r + $signed({{(P_W-RND_W){1'b0}}, fb_rnd})) >>> 11;
    acc      = ACC_W'(fb1_full) + ACC_W'(x) - ACC_W'(fb2_r);
    // saturate 16*s(n) + ff to the output range
    esum     = (ES_W'(sn_r) <<< 4) + ES_W'(ff_r);
    if (esum[ES_W-1:OUT_W-1] == '0 || esum[ES_W-1:OUT_W-1] == '1) begin
      e_nxt = esum[OUT_W-1:0];
    end else if (esum[ES_W-1]) begin
      e_nxt = {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      e_nxt = {1'b0, {(OUT_W-1){1'b1}}};
    end
    // gradient step, clamped coefficient
    g2_full  = (prod_r + 37'sd16384) >>> 15;
    gu       = GU_W'(g2_full) + 23'sd2;
    dstep    = gu[COEF_W+1:2];
    cnew     = CN_W'(coef_r) + CN_W'(dstep);
    if (cnew > CN_W'(COEF_MAX)) begin
      coef_nxt = COEF_MAX;
    end else if (cnew < CN_W'(COEF_MIN)) begin
      coef_nxt = COEF_MIN;
    end else begin
      coef_nxt = cnew[COEF_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ph_r   <= PH_CW;
      coef_r <= '0;
      w1_r   <= '0;
      w2_r   <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      ph_r   <= PH_CW;
    end else if (busy_r) begin
      ph_r <= ph_r + 3'd1;
      if (ph_r == PH_UPD) begin
        busy_r <= 1'b0;
        coef_r <= coef_nxt;
        w2_r   <= w1_r;
        w1_r   <= sn_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (busy_r && ph_r == PH_RW) begin
      ff_r <= ff_nxt;
    end
    if (busy_r && ph_r == PH_RSQ) begin
      fbq_r <= fbq_full[FBQ_W-1:0];
    end
    if (busy_r && ph_r == PH_FB) begin
      fb2_r <= fb2_full[FB2_W-1:0];
    end
    if (busy_r && ph_r == PH_STEP) begin
      sn_r <= acc[COEF_W+3:4];
    end
    if (busy_r && ph_r == PH_ERR) begin
      g_r <= fb2_full[COEF_W-1:0];
      e_r <= e_nxt;
    end
  end

  assign e          = e_r;
  assign stat.e_vld = busy_r && ph_r == PH_GRAD;
  assign stat.done  = busy_r && ph_r == PH_UPD;

  a_coef_range: assert property (@(posedge clk) disable iff (!rst_n)
    coef_r <= COEF_MAX && coef_r >= COEF_MIN)
    else $error("notch coefficient left its clamp range");

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("cell started while busy");

  a_evld_done: assert property (@(posedge clk) disable iff (!rst_n)
    stat.e_vld |=> stat.done)
    else $error("cell output not followed by update step");

endmodule

/* test/notch_result_checker.sv */
`timescale 1ns / 1ps
// Checker for the cascaded notch filter: watches the sample, result and register
// channels, predicts both stage outputs and compares them.
// Depends on canf_pkg and the canf_*_if interfaces.
module notch_result_checker (
  input  logic clk,
  input  logic rst_n,
  canf_in_if   in_mon,
  canf_out_if  out_mon,
  canf_cfg_if  cfg_mon,
  output int   fail_count,
  output int   backlog,
  output int   checked_count
);
  import canf_pkg::*;

  localparam int     REPORT_LIMIT = 10;
  localparam longint OUT_HI       = 1048575;
  localparam longint OUT_LO       = -1048576;
  localparam longint RADIUS_CAP   = 65535;
  localparam longint HALF_Q15     = 16384;
  localparam longint HALF_Q11     = 1024;
  localparam longint HALF_Q9      = 256;
  localparam longint HALF_STEP    = 2;

  typedef struct packed {
    logic signed [OUT_W-1:0] stage_one;
    logic signed [OUT_W-1:0] stage_two;
  } notch_pair_t;

  notch_pair_t expected_pairs[$];

  // predictor copy of the registers and filter state
  longint forget_w, target_w, final_r, step_gain, radius;
  longint coef[2];
  longint taps[4];   // per stage: s(n-1), s(n-2)

  function automatic longint wrap16(input longint v);
    logic signed [15:0] t;
    t = v[15:0];
    return longint'(t);
  endfunction

  function automatic longint sat21(input longint v);
    if (v > OUT_HI) return OUT_HI;
    if (v < OUT_LO) return OUT_LO;
    return v;
  endfunction

  function automatic longint notch_stage(input longint x, input int st, input longint rnd);
    longint c, w1, w2, fb, ff, rsq, sn, e, g;
    c  = coef[st];
    w1 = taps[2*st];
    w2 = taps[2*st+1];
    fb = (radius * w1 + HALF_Q11) >>> 11;
    fb = (c * (fb >>> 2) + rnd) >>> 11;
    ff = ((-c * w1 + HALF_Q9) >>> 9) + w2 * 16;
    rsq = wrap16((radius * radius + HALF_Q15) >>> 15);
    fb = fb - ((w2 * rsq + HALF_Q11) >>> 11);
    sn = wrap16((x + fb) >>> 4);
    e  = sat21(sn * 16 + ff);
    // gradient step on the coefficient, operand and step both wrap to 16 bits
    g = wrap16((step_gain * w1 + HALF_Q11) >>> 11);
    g = (e * g + HALF_Q15) >>> 15;
    c = c + wrap16((g + HALF_STEP) >>> 2);
    if (c < longint'(COEF_MIN)) c = longint'(COEF_MIN);
    if (c > longint'(COEF_MAX)) c = longint'(COEF_MAX);
    coef[st]      = c;
    taps[2*st+1]  = w1;
    taps[2*st]    = sn;
    return e;
  endfunction

  function automatic notch_pair_t predict_pair(input logic signed [SAMPLE_W-1:0] sample);
    notch_pair_t p;
    longint nr, e1, e2;
    nr = ((forget_w * radius + HALF_Q15) >> 15) + ((target_w * final_r + HALF_Q15) >> 15);
    radius = (nr > RADIUS_CAP) ? RADIUS_CAP : nr;
    e1 = notch_stage(longint'(sample), 0, longint'(FB_RND_ST1));
    e2 = notch_stage(e1, 1, longint'(FB_RND_ST2));
    p.stage_one = e1[OUT_W-1:0];
    p.stage_two = e2[OUT_W-1:0];
    return p;
  endfunction

  always @(posedge clk) begin : watch
    notch_pair_t want;
    if (!rst_n) begin
      forget_w  = longint'(FORGET_RST);
      target_w  = longint'(TARGET_RST);
      final_r   = longint'(FINAL_RST);
      step_gain = longint'(STEP_RST);
      radius    = longint'(START_RST);
      coef      = '{0, 0};
      taps      = '{0, 0, 0, 0};
      expected_pairs.delete();
    end else begin
      // results first: a result never belongs to a sample taken at the same edge
      if (out_mon.valid && out_mon.ready) begin
        checked_count++;
        if (expected_pairs.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("%0t: result %0d/%0d with no sample waiting", $time,
                     out_mon.stage_one_out, out_mon.stage_two_out);
        end else begin
          want = expected_pairs.pop_front();
          if (want.stage_one !== out_mon.stage_one_out ||
              want.stage_two !== out_mon.stage_two_out) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
              $display("%0t: mismatch stage one exp %0d got %0d, stage two exp %0d got %0d",
                       $time, want.stage_one, out_mon.stage_one_out,
                       want.stage_two, out_mon.stage_two_out);
          end
        end
      end
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          REG_FORGET: forget_w  = longint'(cfg_mon.data);
          REG_TARGET: target_w  = longint'(cfg_mon.data);
          REG_FINAL:  final_r   = longint'(cfg_mon.data);
          REG_START:  radius    = longint'(cfg_mon.data);  // also reloads the live radius
          REG_STEP:   step_gain = longint'(cfg_mon.data);
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready)
        expected_pairs.push_back(predict_pair(in_mon.sample));
    end
    backlog = expected_pairs.size();
  end

endmodule

/* test/tb_cascaded_adaptive_notch_filter.sv */
`timescale 1ns / 1ps
// Testbench top for the cascaded notch filter: clock, reset, sample and register
// stimulus, result back-pressure and verdict.
// Depends on canf_pkg, the canf_*_if interfaces and notch_result_checker.
module tb_cascaded_adaptive_notch_filter;
  import canf_pkg::*;

  localparam int CLK_HALF       = 10;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int LONG_HOLD      = 400;
  localparam int SETTLE         = 40;
  localparam int PHASE_ITEMS    = 150;
  localparam logic [REG_W-1:0] REG_FULL = '1;

  typedef enum int {SRC_NOISE, SRC_EXTREME, SRC_QUIET, SRC_TONE} sample_src_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  canf_in_if  in_ch();
  canf_out_if out_ch();
  canf_cfg_if cfg_ch();

  int fail_count, backlog, checked_count;
  int items_sent, cfg_writes, burst_left, gap_max, quiet_cycles;
  bit hold_req, hold_done;
  logic [15:0] stall_mask;
  int stall_tick;

  logic signed [SAMPLE_W-1:0] corners_default[14] = '{0, 32767, 32767, -32768, -32768, 32767,
                                                     -32768, 1, -1, 0, 21845, -21846, 32767, 0};
  logic signed [SAMPLE_W-1:0] corners_full[10] = '{32767, 32767, 32767, -32768, -32768, -32768,
                                                  32767, -1, 0, 12345};

  cascaded_adaptive_notch_filter i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  notch_result_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .cfg_mon       (cfg_ch),
    .fail_count    (fail_count),
    .backlog       (backlog),
    .checked_count (checked_count)
  );

  always #(CLK_HALF) clk = ~clk;

  // sample offered in bursts, random gap before each burst
  task automatic push_sample(input logic signed [SAMPLE_W-1:0] x);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      repeat (gap) begin
        @(negedge clk);
        in_ch.valid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    in_ch.valid  <= 1'b1;
    in_ch.sample <= x;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    wait (backlog == 0);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [REG_W-1:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    cfg_writes++;
  endtask

  // only while idle: every result of the previous setting has been taken
  task automatic load_config(input logic [REG_W-1:0] forget, input logic [REG_W-1:0] target,
                             input logic [REG_W-1:0] final_r, input logic [REG_W-1:0] start,
                             input logic [REG_W-1:0] step);
    drain();
    write_reg(REG_FORGET, forget);
    write_reg(REG_TARGET, target);
    write_reg(REG_FINAL, final_r);
    write_reg(REG_START, start);
    write_reg(REG_STEP, step);
    // unused index, must be ignored
    write_reg(IDX_W'(REG_STEP + 1 + $urandom_range(0, 2)), REG_W'($urandom_range(0, 32767)));
  endtask

  task automatic random_phase(input int count);
    sample_src_t src;
    int run_len, period, amp, v, k;
    while (count > 0) begin
      src     = ($urandom_range(0, 7) > 3) ? SRC_TONE : sample_src_t'($urandom_range(0, 2));
      run_len = $urandom_range(8, 48);
      period  = $urandom_range(4, 32);
      amp     = $urandom_range(0, 32767);
      for (k = 0; k < run_len && count > 0; k++) begin
        case (src)
          SRC_NOISE:   v = int'($urandom_range(0, 65535)) - 32768;
          SRC_EXTREME: v = $urandom_range(0, 1) ? 32767 : -32768;
          SRC_QUIET:   v = int'($urandom_range(0, 512)) - 256;
          default:     v = (((k % period) < period / 2) ? amp : -amp)
                           + int'($urandom_range(0, 31)) - 16;
        endcase
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        push_sample(v[SAMPLE_W-1:0]);
        count--;
      end
    end
  endtask

  // result side: own stall pattern, plus one long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    stall_tick   = 0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD - 1) begin
          @(negedge clk);
          out_ch.ready <= 1'b0;
        end
      end else begin
        if (stall_tick == 0) begin
          stall_tick = 64;
          if ($urandom_range(0, 3) == 0) stall_mask = '1;
          else stall_mask = 16'($urandom()) | (16'h1 << $urandom_range(0, 15));
        end
        stall_tick--;
        out_ch.ready <= stall_mask[stall_tick % 16];
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("watchdog: nothing moved for %0d cycles", WATCHDOG_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    in_ch.valid  = 1'b0;
    in_ch.sample = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data  = '0;
    burst_left   = 0;
    gap_max      = 8;
    hold_req     = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: reset setting, then every register at full scale
    // (radius saturates, squared radius and gradient operand wrap)
    foreach (corners_default[i]) push_sample(corners_default[i]);
    load_config(REG_FULL, REG_FULL, REG_FULL, REG_FULL, REG_FULL);
    foreach (corners_full[i]) push_sample(corners_full[i]);

    load_config('0, '0, '0, '0, '0);
    random_phase(PHASE_ITEMS);

    load_config(FORGET_RST, TARGET_RST, FINAL_RST, START_RST, STEP_RST);
    hold_req = 1'b1;
    random_phase(PHASE_ITEMS);

    // no idling on the sender, pause halfway until everything is back
    gap_max = 0;
    load_config(REG_W'($urandom_range(0, 32767)), REG_W'($urandom_range(0, 32767)),
                REG_W'($urandom_range(0, 32767)), REG_W'($urandom_range(0, 32767)),
                REG_W'($urandom_range(0, 32767)));
    random_phase(PHASE_ITEMS / 2);
    drain();
    random_phase(PHASE_ITEMS / 2);

    gap_max = 30;
    load_config(REG_FULL, REG_FULL, REG_FULL, REG_FULL, REG_FULL);
    random_phase(PHASE_ITEMS);

    gap_max = 12;
    load_config(REG_W'($urandom_range(28000, 32767)), REG_W'($urandom_range(0, 4000)),
                REG_W'($urandom_range(24000, 32767)), REG_W'($urandom_range(0, 32767)),
                REG_W'($urandom_range(0, 2000)));
    random_phase(PHASE_ITEMS);

    repeat (2) begin
      load_config(REG_W'($urandom_range(0, 32767)), REG_W'($urandom_range(0, 32767)),
                  REG_W'($urandom_range(0, 32767)), REG_W'($urandom_range(0, 32767)),
                  REG_W'($urandom_range(0, 32767)));
      random_phase(PHASE_ITEMS);
    end

    drain();
    repeat (SETTLE) @(posedge clk);
    $display("Covered %0d samples (%0d directed) under 9 register settings, %0d register writes",
             items_sent, $size(corners_default) + $size(corners_full), cfg_writes);
    $display("Checked %0d results, %0d failures, long result stall and sender pause included",
             checked_count, fail_count);
    if (fail_count == 0 && backlog == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
